[design/psd_pkg.sv]
// Shared types, stream codes and helper functions of the program stream demultiplexer.
`default_nettype none

package psd_pkg;

  // Parser phases, one per position in the element grammar.
  typedef enum logic [3:0] {
    PH_SC0,
    PH_SC1,
    PH_SC2,
    PH_ID,
    PH_PACK,
    PH_SKIP,
    PH_LEN_HI,
    PH_LEN_LO,
    PH_HDR1,
    PH_HDR2,
    PH_HDR3,
    PH_HSKIP,
    PH_PAYLOAD,
    PH_ERROR
  } phase_e;

  // Indexes of the element counters.
  typedef enum logic [2:0] {
    KIND_PACK,
    KIND_SYS,
    KIND_MAP,
    KIND_PES,
    KIND_VIDEO,
    KIND_AUDIO,
    KIND_PRIV
  } kind_e;

  localparam int unsigned KindCount = 7;

  // Stream id codes.
  localparam logic [7:0] ID_PACK     = 8'hBA;
  localparam logic [7:0] ID_SYS      = 8'hBB;
  localparam logic [7:0] ID_MAP      = 8'hBC;
  localparam logic [7:0] ID_PRIV1    = 8'hBD;
  localparam logic [7:0] ID_PAD      = 8'hBE;
  localparam logic [7:0] ID_PRIV2    = 8'hBF;
  localparam logic [7:0] ID_PRIV3    = 8'hFD;
  localparam logic [7:0] ID_AUDIO_LO = 8'hC0;
  localparam logic [7:0] ID_AUDIO_HI = 8'hDF;
  localparam logic [7:0] ID_VIDEO_LO = 8'hE0;
  localparam logic [7:0] ID_VIDEO_HI = 8'hEF;

  // Start code bytes.
  localparam logic [7:0] SC_ZERO = 8'h00;
  localparam logic [7:0] SC_ONE  = 8'h01;

  // Top two bits of an optional PES header's first byte.
  localparam logic [1:0] HDR_MARK = 2'b10;

  // Pack header byte positions: the id ends byte 3, the stuffing length sits in byte 13.
  localparam logic [3:0] PACK_FIRST_POS = 4'd4;
  localparam logic [3:0] PACK_LAST_POS  = 4'd13;

  // Known lengths below this carry no optional header.
  localparam logic [15:0] MIN_HDR_LEN = 16'd3;

  // Final status codes.
  localparam logic [1:0] STATUS_UNFINISHED = 2'd0;
  localparam logic [1:0] STATUS_ACCEPTED   = 2'd1;
  localparam logic [1:0] STATUS_NO_MEDIA   = 2'd2;
  localparam logic [1:0] STATUS_MALFORMED  = 2'd3;

  // Depth of the result queue; one byte may push up to MaxResults results.
  localparam int unsigned OutDepth   = 4;
  localparam int unsigned MaxResults = 3;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       end_of_buffer;
  } in_beat_t;

  typedef struct packed {
    logic        payload_valid;
    logic [7:0]  payload_value;
    logic        run_last;
    logic [1:0]  status;
    logic [15:0] pack_count;
    logic [15:0] system_header_count;
    logic [15:0] map_count;
    logic [15:0] pes_count;
    logic [15:0] video_count;
    logic [15:0] audio_count;
    logic [15:0] private_count;
    logic [31:0] payload_total;
  } out_beat_t;

  function automatic logic is_video(input logic [7:0] c);
    return (c >= ID_VIDEO_LO) && (c <= ID_VIDEO_HI);
  endfunction

  function automatic logic is_audio(input logic [7:0] c);
    return (c >= ID_AUDIO_LO) && (c <= ID_AUDIO_HI);
  endfunction

  function automatic logic is_private(input logic [7:0] c);
    return (c == ID_PRIV1) || (c == ID_PRIV2) || (c == ID_PRIV3);
  endfunction

  function automatic logic is_pes(input logic [7:0] c);
    return is_private(c) || (c == ID_PAD) || ((c >= ID_AUDIO_LO) && (c <= ID_VIDEO_HI));
  endfunction

endpackage

`default_nettype wire

[design/psd_stream_if.sv]
// Valid/ready stream channel carrying one payload beat.
`default_nettype none

interface psd_stream_if #(
  parameter type payload_t = logic [7:0]
);
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

`default_nettype wire

[design/program_stream_demux_parser_top.sv]
// Top level of the program stream demultiplexer: input register, parser step, result queue.
//
// Channel   Dir  Beat                                Meaning
// in_i      in   data_byte, end_of_buffer            one program stream byte
// out_o     out  payload_valid .. payload_total      one video byte or the final status
//
// Bytes are accepted back to back while the queue has room for a byte's results.
// A byte yields zero to three results; the queue holds four, and the input
// register waits while fewer than three entries are free, so a burst of three
// results holds the next byte back.
// Reset is asynchronous, active low, and clears the parser's control state and the queue's pointers and fill.
// A stalled output fills the queue and then holds the input register.
`default_nettype none

module program_stream_demux_parser_top #(
  parameter int unsigned COUNT_WIDTH = 16,
  parameter int unsigned TOTAL_WIDTH = 32
) (
  input  wire           clk_i,
  input  wire           rst_ni,
  psd_stream_if.sink    in_i,
  psd_stream_if.source  out_o
);

  logic              in_valid_q, in_valid_d;
  psd_pkg::in_beat_t in_beat_q;
  logic              space;
  logic              advance;
  logic              in_fire;
  psd_pkg::out_beat_t [psd_pkg::MaxResults-1:0] res;
  logic [1:0]        res_n;

  // The held byte moves on whenever the queue has room for its results.
  assign advance    = in_valid_q && space;
  assign in_i.ready = !in_valid_q || space;
  assign in_fire    = in_i.valid && in_i.ready;

  always_comb begin
    in_valid_d = in_valid_q;
    if (in_fire) in_valid_d = 1'b1;
    else if (advance) in_valid_d = 1'b0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else begin
      in_valid_q <= in_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) in_beat_q <= in_i.payload;
  end

  psd_step #(
    .COUNT_WIDTH (COUNT_WIDTH),
    .TOTAL_WIDTH (TOTAL_WIDTH)
  ) u_step (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .step_en_i (advance),
    .beat_i    (in_beat_q),
    .res_o     (res),
    .res_n_o   (res_n)
  );

  psd_out_fifo u_fifo (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .push_i   (res),
    .push_n_i (res_n),
    .space_o  (space),
    .out_o    (out_o)
  );

endmodule

`default_nettype wire

[design/psd_step.sv]
// Parser state and the per-byte step that produces up to three results.
`default_nettype none

module psd_step #(
  parameter int unsigned COUNT_WIDTH = 16,
  parameter int unsigned TOTAL_WIDTH = 32
) (
  input  wire                                  clk_i,
  input  wire                                  rst_ni,
  input  wire                                  step_en_i,
  input  psd_pkg::in_beat_t                    beat_i,
  output psd_pkg::out_beat_t [psd_pkg::MaxResults-1:0] res_o,
  output logic [1:0]                           res_n_o
);

  localparam int unsigned NumCand = psd_pkg::MaxResults + 1;

  // Parser state.
  psd_pkg::phase_e phase_q, phase_d;
  logic [3:0]  position_q, position_d;
  logic [7:0]  code_q, code_d;
  logic [15:0] remaining_q, remaining_d;
  logic        runs_q, runs_d;
  logic [7:0]  hdr_left_q, hdr_left_d;
  logic [7:0]  held_q [2];
  logic [7:0]  held_d [2];
  logic [1:0]  held_cnt_q, held_cnt_d;
  logic        error_q, error_d;
  logic [COUNT_WIDTH-1:0] cnt_q [psd_pkg::KindCount];
  logic [COUNT_WIDTH-1:0] cnt_d [psd_pkg::KindCount];
  logic [TOTAL_WIDTH-1:0] total_q, total_d;

  logic        inc [psd_pkg::KindCount];
  logic        take_main;
  logic        do_fail;
  logic [7:0]  b;
  logic        last;
  logic [15:0] rem_dec;
  logic [15:0] rem_hdr;
  logic [15:0] len;
  logic [7:0]  hdr_left_dec;

  assign b    = beat_i.data_byte;
  assign last = beat_i.end_of_buffer;

  // Next state of the grammar walk for one byte.
  always_comb begin : next_state
    phase_d      = phase_q;
    position_d   = position_q;
    code_d       = code_q;
    remaining_d  = remaining_q;
    runs_d       = runs_q;
    hdr_left_d   = hdr_left_q;
    held_d[0]    = held_q[0];
    held_d[1]    = held_q[1];
    held_cnt_d   = held_cnt_q;
    error_d      = error_q;
    take_main    = 1'b0;
    do_fail      = 1'b0;
    for (int k = 0; k < psd_pkg::KindCount; k++) begin
      inc[k] = 1'b0;
    end
    rem_dec      = (remaining_q != 16'd0) ? remaining_q - 16'd1 : remaining_q;
    rem_hdr      = remaining_q - 16'd1 - {8'd0, b};
    len          = {remaining_q[15:8], b};
    hdr_left_dec = (hdr_left_q != 8'd0) ? hdr_left_q - 8'd1 : hdr_left_q;

    if (step_en_i && !error_q) begin
      unique case (phase_q)
        psd_pkg::PH_SC0: begin
          if (b == psd_pkg::SC_ZERO) phase_d = psd_pkg::PH_SC1;
          else do_fail = 1'b1;
        end
        psd_pkg::PH_SC1: begin
          if (b == psd_pkg::SC_ZERO) phase_d = psd_pkg::PH_SC2;
          else do_fail = 1'b1;
        end
        psd_pkg::PH_SC2: begin
          if (b == psd_pkg::SC_ONE) phase_d = psd_pkg::PH_ID;
          else do_fail = 1'b1;
        end
        psd_pkg::PH_ID: begin
          code_d     = b;
          runs_d     = 1'b0;
          held_cnt_d = 2'd0;
          if (b == psd_pkg::ID_PACK) begin
            position_d = psd_pkg::PACK_FIRST_POS;
            phase_d    = psd_pkg::PH_PACK;
          end else if (b == psd_pkg::ID_SYS || b == psd_pkg::ID_MAP) begin
            phase_d = psd_pkg::PH_LEN_HI;
          end else if (psd_pkg::is_pes(b)) begin
            inc[psd_pkg::KIND_PES]   = 1'b1;
            inc[psd_pkg::KIND_VIDEO] = psd_pkg::is_video(b);
            inc[psd_pkg::KIND_AUDIO] = psd_pkg::is_audio(b);
            inc[psd_pkg::KIND_PRIV]  = psd_pkg::is_private(b);
            phase_d = psd_pkg::PH_LEN_HI;
          end else begin
            do_fail = 1'b1;
          end
        end
        psd_pkg::PH_PACK: begin
          if (position_q >= psd_pkg::PACK_LAST_POS) begin
            inc[psd_pkg::KIND_PACK] = 1'b1;
            remaining_d = {13'd0, b[2:0]};
            phase_d = (b[2:0] != 3'd0) ? psd_pkg::PH_SKIP : psd_pkg::PH_SC0;
          end else begin
            position_d = position_q + 4'd1;
          end
        end
        psd_pkg::PH_SKIP: begin
          remaining_d = rem_dec;
          if (rem_dec == 16'd0) phase_d = psd_pkg::PH_SC0;
        end
        psd_pkg::PH_LEN_HI: begin
          remaining_d = {b, 8'd0};
          phase_d     = psd_pkg::PH_LEN_LO;
        end
        psd_pkg::PH_LEN_LO: begin
          remaining_d = len;
          if (code_q == psd_pkg::ID_SYS || code_q == psd_pkg::ID_MAP) begin
            inc[psd_pkg::KIND_SYS] = (code_q == psd_pkg::ID_SYS);
            inc[psd_pkg::KIND_MAP] = (code_q == psd_pkg::ID_MAP);
            phase_d = (len != 16'd0) ? psd_pkg::PH_SKIP : psd_pkg::PH_SC0;
          end else if (len == 16'd0) begin
            runs_d  = 1'b1;
            phase_d = (code_q == psd_pkg::ID_PAD) ? psd_pkg::PH_PAYLOAD : psd_pkg::PH_HDR1;
          end else if (code_q == psd_pkg::ID_PAD || len < psd_pkg::MIN_HDR_LEN) begin
            phase_d = psd_pkg::PH_PAYLOAD;
          end else begin
            phase_d = psd_pkg::PH_HDR1;
          end
        end
        psd_pkg::PH_HDR1: begin
          if (b[7:6] == psd_pkg::HDR_MARK) begin
            if (runs_q) begin
              held_d[0]  = b;
              held_cnt_d = 2'd1;
            end else begin
              remaining_d = remaining_q - 16'd1;
            end
            phase_d = psd_pkg::PH_HDR2;
          end else begin
            // Not an optional header: this byte is already payload.
            phase_d   = psd_pkg::PH_PAYLOAD;
            take_main = 1'b1;
            if (!runs_q) begin
              remaining_d = remaining_q - 16'd1;
              if (remaining_q == 16'd1) phase_d = psd_pkg::PH_SC0;
            end
          end
        end
        psd_pkg::PH_HDR2: begin
          if (runs_q) begin
            held_d[1]  = b;
            held_cnt_d = 2'd2;
          end else begin
            remaining_d = remaining_q - 16'd1;
          end
          phase_d = psd_pkg::PH_HDR3;
        end
        psd_pkg::PH_HDR3: begin
          held_cnt_d = 2'd0;
          hdr_left_d = b;
          // A known length must still cover the header data after this byte.
          if (!runs_q && ({8'd0, b} >= remaining_q)) begin
            do_fail = 1'b1;
          end else begin
            if (!runs_q) remaining_d = rem_hdr;
            if (b != 8'd0) phase_d = psd_pkg::PH_HSKIP;
            else if (!runs_q && rem_hdr == 16'd0) phase_d = psd_pkg::PH_SC0;
            else phase_d = psd_pkg::PH_PAYLOAD;
          end
        end
        psd_pkg::PH_HSKIP: begin
          hdr_left_d = hdr_left_dec;
          if (hdr_left_dec == 8'd0) begin
            phase_d = (!runs_q && remaining_q == 16'd0) ? psd_pkg::PH_SC0
                                                        : psd_pkg::PH_PAYLOAD;
          end
        end
        psd_pkg::PH_PAYLOAD: begin
          take_main = 1'b1;
          if (!runs_q) begin
            remaining_d = rem_dec;
            if (rem_dec == 16'd0) phase_d = psd_pkg::PH_SC0;
          end
        end
        default: begin
          do_fail = 1'b1;
        end
      endcase
    end

    if (do_fail) begin
      phase_d = psd_pkg::PH_ERROR;
      error_d = 1'b1;
    end

    // Saturating element counters.
    for (int k = 0; k < psd_pkg::KindCount; k++) begin
      cnt_d[k] = (inc[k] && cnt_q[k] != {COUNT_WIDTH{1'b1}}) ? cnt_q[k] + 1'b1 : cnt_q[k];
    end
  end

  // End-of-buffer decision, held-byte flush and the payload total.
  logic       ok;
  logic       flush;
  logic       main_pay;
  logic       take_f0;
  logic       take_f1;
  logic [1:0] takes;
  logic [TOTAL_WIDTH:0] total_sum;
  logic [1:0] status;

  always_comb begin : finish
    ok = !error_d && ((phase_d == psd_pkg::PH_SC0) ||
         (runs_d && (phase_d == psd_pkg::PH_HDR1 || phase_d == psd_pkg::PH_HDR2 ||
                     phase_d == psd_pkg::PH_HDR3 || phase_d == psd_pkg::PH_PAYLOAD)));
    flush    = step_en_i && last && ok && (phase_d != psd_pkg::PH_SC0);
    main_pay = take_main && (code_q != psd_pkg::ID_PAD);
    take_f0  = flush && (held_cnt_d != 2'd0) && (code_q != psd_pkg::ID_PAD);
    take_f1  = flush && held_cnt_d[1] && (code_q != psd_pkg::ID_PAD);
    takes    = {1'b0, main_pay} + {1'b0, take_f0} + {1'b0, take_f1};
    total_sum = {1'b0, total_q} + {{(TOTAL_WIDTH-1){1'b0}}, takes};
    total_d  = total_sum[TOTAL_WIDTH] ? {TOTAL_WIDTH{1'b1}} : total_sum[TOTAL_WIDTH-1:0];

    if (!ok) begin
      status = psd_pkg::STATUS_MALFORMED;
    end else if (cnt_d[psd_pkg::KIND_PACK] != '0 &&
                 (cnt_d[psd_pkg::KIND_VIDEO] != '0 || cnt_d[psd_pkg::KIND_AUDIO] != '0 ||
                  cnt_d[psd_pkg::KIND_PRIV] != '0)) begin
      status = psd_pkg::STATUS_ACCEPTED;
    end else begin
      status = psd_pkg::STATUS_NO_MEDIA;
    end
  end

  // Counts as shown on the status result, cut or widened to the field widths.
  logic [COUNT_WIDTH+15:0] cnt_ext [psd_pkg::KindCount];
  logic [TOTAL_WIDTH+31:0] total_ext;

  always_comb begin : widen
    for (int k = 0; k < psd_pkg::KindCount; k++) begin
      cnt_ext[k] = ok ? {16'd0, cnt_d[k]} : '0;
    end
    total_ext = ok ? {32'd0, total_d} : '0;
  end

  // Results of this byte, packed in order into the first slots.
  psd_pkg::out_beat_t cand    [NumCand];
  logic               cand_en [NumCand];
  logic [1:0]         n;

  always_comb begin : outputs
    for (int c = 0; c < NumCand; c++) begin
      cand[c] = '0;
      cand[c].payload_valid = 1'b1;
    end
    cand[0].payload_value = b;
    cand[1].payload_value = held_d[0];
    cand[2].payload_value = held_d[1];
    cand[3].payload_valid = 1'b0;
    cand[3].status              = status;
    cand[3].pack_count          = cnt_ext[psd_pkg::KIND_PACK][15:0];
    cand[3].system_header_count = cnt_ext[psd_pkg::KIND_SYS][15:0];
    cand[3].map_count           = cnt_ext[psd_pkg::KIND_MAP][15:0];
    cand[3].pes_count           = cnt_ext[psd_pkg::KIND_PES][15:0];
    cand[3].video_count         = cnt_ext[psd_pkg::KIND_VIDEO][15:0];
    cand[3].audio_count         = cnt_ext[psd_pkg::KIND_AUDIO][15:0];
    cand[3].private_count       = cnt_ext[psd_pkg::KIND_PRIV][15:0];
    cand[3].payload_total       = total_ext[31:0];

    cand_en[0] = take_main && psd_pkg::is_video(code_q);
    cand_en[1] = take_f0 && psd_pkg::is_video(code_q);
    cand_en[2] = take_f1 && psd_pkg::is_video(code_q);
    cand_en[3] = step_en_i && last;

    res_o = '0;
    n     = 2'd0;
    for (int c = 0; c < NumCand; c++) begin
      if (cand_en[c] && n != 2'd3) begin
        res_o[n] = cand[c];
        n = n + 2'd1;
      end
    end
    if (n != 2'd0) res_o[n - 2'd1].run_last = 1'b1;
    res_n_o = n;
  end

  // Control state; the end of a buffer returns everything to reset.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q    <= psd_pkg::PH_SC0;
      position_q <= 4'd0;
      code_q     <= 8'd0;
      remaining_q <= 16'd0;
      runs_q     <= 1'b0;
      hdr_left_q <= 8'd0;
      held_cnt_q <= 2'd0;
      error_q    <= 1'b0;
      total_q    <= '0;
      for (int k = 0; k < psd_pkg::KindCount; k++) cnt_q[k] <= '0;
    end else if (step_en_i) begin
      if (last) begin
        phase_q    <= psd_pkg::PH_SC0;
        position_q <= 4'd0;
        code_q     <= 8'd0;
        remaining_q <= 16'd0;
        runs_q     <= 1'b0;
        hdr_left_q <= 8'd0;
        held_cnt_q <= 2'd0;
        error_q    <= 1'b0;
        total_q    <= '0;
        for (int k = 0; k < psd_pkg::KindCount; k++) cnt_q[k] <= '0;
      end else begin
        phase_q    <= phase_d;
        position_q <= position_d;
        code_q     <= code_d;
        remaining_q <= remaining_d;
        runs_q     <= runs_d;
        hdr_left_q <= hdr_left_d;
        held_cnt_q <= held_cnt_d;
        error_q    <= error_d;
        total_q    <= total_d;
        for (int k = 0; k < psd_pkg::KindCount; k++) cnt_q[k] <= cnt_d[k];
      end
    end
  end

  // Held header bytes are only read below the held count.
  always_ff @(posedge clk_i) begin
    if (step_en_i) begin
      held_q[0] <= held_d[0];
      held_q[1] <= held_d[1];
    end
  end

  // The error phase is only entered together with the error flag.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == psd_pkg::PH_ERROR) |-> error_q)
    else $error("error phase without error flag");

  // Held bytes exist only inside the header of a packet that runs to the end.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (held_cnt_q != 2'd0) |->
      (runs_q && (phase_q == psd_pkg::PH_HDR2 || phase_q == psd_pkg::PH_HDR3)))
    else $error("held bytes outside an open header");

  // A buffer's final byte leaves the parser clean for the next buffer.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (step_en_i && last) |=> (phase_q == psd_pkg::PH_SC0 && !error_q && total_q == '0))
    else $error("state not cleared after end of buffer");

endmodule

`default_nettype wire

[design/psd_out_fifo.sv]
// Result queue: takes up to three results per cycle and hands out one beat per cycle while the receiver is ready.
`default_nettype none

module psd_out_fifo (
  input  wire                                          clk_i,
  input  wire                                          rst_ni,
  input  psd_pkg::out_beat_t [psd_pkg::MaxResults-1:0] push_i,
  input  wire  [1:0]                                   push_n_i,
  output logic                                         space_o,
  psd_stream_if.source                                 out_o
);

  localparam int unsigned PtrW = $clog2(psd_pkg::OutDepth);
  localparam int unsigned CntW = $clog2(psd_pkg::OutDepth + 1);

  psd_pkg::out_beat_t mem_q [psd_pkg::OutDepth];
  logic [PtrW-1:0] wr_q, wr_d;
  logic [PtrW-1:0] rd_q, rd_d;
  logic [CntW-1:0] count_q, count_d;
  logic [PtrW-1:0] widx [psd_pkg::MaxResults];
  logic            pop;

  assign pop         = out_o.valid && out_o.ready;
  assign out_o.valid = (count_q != '0);
  assign out_o.payload = mem_q[rd_q];
  // Room for a whole byte's worth of results, whatever leaves this cycle.
  assign space_o = (count_q <= CntW'(psd_pkg::OutDepth - psd_pkg::MaxResults));

  // Pointer and fill bookkeeping.
  always_comb begin
    for (int i = 0; i < psd_pkg::MaxResults; i++) begin
      widx[i] = wr_q + PtrW'(i);
    end
    wr_d    = wr_q + PtrW'(push_n_i);
    rd_d    = pop ? rd_q + PtrW'(1) : rd_q;
    count_d = count_q + CntW'(push_n_i) - CntW'(pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q    <= '0;
      rd_q    <= '0;
      count_q <= '0;
    end else begin
      wr_q    <= wr_d;
      rd_q    <= rd_d;
      count_q <= count_d;
    end
  end

  // Entry storage, written in result order.
  always_ff @(posedge clk_i) begin
    for (int i = 0; i < psd_pkg::MaxResults; i++) begin
      if (2'(i) < push_n_i) mem_q[widx[i]] <= push_i[i];
    end
  end

  // Fill level never passes the depth.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntW'(psd_pkg::OutDepth))
    else $error("result queue overfilled");

  // Results are only pushed when a full byte's worth of room was there.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push_n_i != 2'd0) |-> space_o)
    else $error("results pushed without room");

endmodule

`default_nettype wire

[sim/tb_top.sv]
// Self-checking testbench of the program stream demultiplexer with its own byte-level predictor.
`timescale 1ns / 100ps

module tb_top;

  localparam int unsigned CYCLE_LIMIT = 400000;
  localparam int unsigned LONG_HOLD   = 120;
  localparam int unsigned SETTLE      = 20;
  localparam int unsigned ITEM_GOAL   = 250;

  // Expectation forced by a directed row instead of the predictor.
  typedef struct {
    bit                 typed;
    psd_pkg::out_beat_t beat;
  } typed_expect_t;

  // One row of the directed table.
  typedef struct {
    logic [7:0]         data;
    logic               eob;
    bit                 typed;
    psd_pkg::out_beat_t want;
  } stim_row_t;

  logic clk_i = 1'b0;
  logic rst_ni;

  psd_stream_if #(.payload_t(psd_pkg::in_beat_t))  in_ch ();
  psd_stream_if #(.payload_t(psd_pkg::out_beat_t)) out_ch ();

  program_stream_demux_parser_top i_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_ch),
    .out_o  (out_ch)
  );

  // Clock with a 10 ns period.
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Parser state as the predictor sees it.
  psd_pkg::phase_e st_phase;
  logic [4:0]  st_pos;
  logic [7:0]  st_code;
  logic [16:0] st_left;
  logic        st_to_end;
  logic [7:0]  st_hdr_left;
  logic [7:0]  st_held [2];
  logic [1:0]  st_held_n;
  logic        st_err;
  logic [15:0] st_kind [psd_pkg::KindCount];
  logic [31:0] st_total;

  psd_pkg::out_beat_t step_beats[$];
  psd_pkg::out_beat_t demux_results_q[$];
  typed_expect_t      typed_q[$];
  stim_row_t          stim_rows[$];
  logic [7:0]         buf_bytes[$];

  int unsigned mismatches  = 0;
  int unsigned cycle_count = 0;
  int unsigned sent_items  = 0;
  bit          quiet       = 1'b1;
  bit          hold_req    = 1'b0;

  // Return the predictor to its state after reset.
  task automatic clear_parser();
    st_phase    = psd_pkg::PH_SC0;
    st_pos      = '0;
    st_code     = '0;
    st_left     = '0;
    st_to_end   = 1'b0;
    st_hdr_left = '0;
    st_held[0]  = '0;
    st_held[1]  = '0;
    st_held_n   = '0;
    st_err      = 1'b0;
    foreach (st_kind[i]) st_kind[i] = '0;
    st_total    = '0;
  endtask

  function automatic bit video_id(logic [7:0] c);
    return (c >= psd_pkg::ID_VIDEO_LO) && (c <= psd_pkg::ID_VIDEO_HI);
  endfunction

  function automatic bit audio_id(logic [7:0] c);
    return (c >= psd_pkg::ID_AUDIO_LO) && (c <= psd_pkg::ID_AUDIO_HI);
  endfunction

  function automatic bit private_id(logic [7:0] c);
    return (c == psd_pkg::ID_PRIV1) || (c == psd_pkg::ID_PRIV2) || (c == psd_pkg::ID_PRIV3);
  endfunction

  task automatic bump_kind(psd_pkg::kind_e k);
    if (st_kind[k] != '1) st_kind[k] = st_kind[k] + 1'b1;
  endtask

  task automatic fail_parse();
    st_phase = psd_pkg::PH_ERROR;
    st_err   = 1'b1;
  endtask

  // Queue one result; counts are only shown on a status beat.
  task automatic emit(logic valid, logic [7:0] value, logic [1:0] status);
    psd_pkg::out_beat_t r;
    r = '0;
    r.payload_valid = valid;
    r.payload_value = value;
    r.status        = status;
    if (status != psd_pkg::STATUS_UNFINISHED) begin
      r.pack_count          = st_kind[psd_pkg::KIND_PACK];
      r.system_header_count = st_kind[psd_pkg::KIND_SYS];
      r.map_count           = st_kind[psd_pkg::KIND_MAP];
      r.pes_count           = st_kind[psd_pkg::KIND_PES];
      r.video_count         = st_kind[psd_pkg::KIND_VIDEO];
      r.audio_count         = st_kind[psd_pkg::KIND_AUDIO];
      r.private_count       = st_kind[psd_pkg::KIND_PRIV];
      r.payload_total       = st_total;
    end
    step_beats.insert(step_beats.size(), r);
  endtask

  // Count a payload byte of a non-padding packet and pass video bytes on.
  task automatic take_byte(logic [7:0] d);
    if (st_code == psd_pkg::ID_PAD) return;
    if (st_total != '1) st_total = st_total + 1'b1;
    if (video_id(st_code)) emit(1'b1, d, psd_pkg::STATUS_UNFINISHED);
  endtask

  // Predict the results of one input beat into step_beats.
  task automatic demux_step(psd_pkg::in_beat_t b);
    logic [7:0] d;
    logic       ok;
    logic       bad;
    logic [1:0] fin;
    d   = b.data_byte;
    bad = 1'b0;
    step_beats.delete();
    if (!st_err) begin
      case (st_phase)
        psd_pkg::PH_SC0: begin
          if (d == psd_pkg::SC_ZERO) st_phase = psd_pkg::PH_SC1;
          else fail_parse();
        end
        psd_pkg::PH_SC1: begin
          if (d == psd_pkg::SC_ZERO) st_phase = psd_pkg::PH_SC2;
          else fail_parse();
        end
        psd_pkg::PH_SC2: begin
          if (d == psd_pkg::SC_ONE) st_phase = psd_pkg::PH_ID;
          else fail_parse();
        end
        psd_pkg::PH_ID: begin
          st_code   = d;
          st_to_end = 1'b0;
          st_held_n = '0;
          if (d == psd_pkg::ID_PACK) begin
            st_pos   = 5'(psd_pkg::PACK_FIRST_POS);
            st_phase = psd_pkg::PH_PACK;
          end else if (d == psd_pkg::ID_SYS || d == psd_pkg::ID_MAP) begin
            st_phase = psd_pkg::PH_LEN_HI;
          end else if (private_id(d) || d == psd_pkg::ID_PAD ||
                       (d >= psd_pkg::ID_AUDIO_LO && d <= psd_pkg::ID_VIDEO_HI)) begin
            bump_kind(psd_pkg::KIND_PES);
            if (video_id(d)) bump_kind(psd_pkg::KIND_VIDEO);
            else if (audio_id(d)) bump_kind(psd_pkg::KIND_AUDIO);
            else if (private_id(d)) bump_kind(psd_pkg::KIND_PRIV);
            st_phase = psd_pkg::PH_LEN_HI;
          end else begin
            fail_parse();
          end
        end
        psd_pkg::PH_PACK: begin
          if (st_pos >= 5'(psd_pkg::PACK_LAST_POS)) begin
            bump_kind(psd_pkg::KIND_PACK);
            st_left  = {14'b0, d[2:0]};
            st_phase = (st_left != 0) ? psd_pkg::PH_SKIP : psd_pkg::PH_SC0;
          end else begin
            st_pos = st_pos + 1'b1;
          end
        end
        psd_pkg::PH_SKIP: begin
          if (st_left > 0) st_left = st_left - 1'b1;
          if (st_left == 0) st_phase = psd_pkg::PH_SC0;
        end
        psd_pkg::PH_LEN_HI: begin
          st_left  = {1'b0, d, 8'h00};
          st_phase = psd_pkg::PH_LEN_LO;
        end
        psd_pkg::PH_LEN_LO: begin
          st_left[7:0] = d;
          if (st_code == psd_pkg::ID_SYS || st_code == psd_pkg::ID_MAP) begin
            if (st_code == psd_pkg::ID_SYS) bump_kind(psd_pkg::KIND_SYS);
            else bump_kind(psd_pkg::KIND_MAP);
            st_phase = (st_left != 0) ? psd_pkg::PH_SKIP : psd_pkg::PH_SC0;
          end else if (st_left == 0) begin
            st_to_end = 1'b1;
            st_phase  = (st_code == psd_pkg::ID_PAD) ? psd_pkg::PH_PAYLOAD : psd_pkg::PH_HDR1;
          end else if (st_code == psd_pkg::ID_PAD || st_left < 17'(psd_pkg::MIN_HDR_LEN)) begin
            st_phase = psd_pkg::PH_PAYLOAD;
          end else begin
            st_phase = psd_pkg::PH_HDR1;
          end
        end
        psd_pkg::PH_HDR1: begin
          if (d[7:6] == psd_pkg::HDR_MARK) begin
            if (st_to_end) begin
              st_held[0] = d;
              st_held_n  = 2'd1;
            end else begin
              st_left = st_left - 1'b1;
            end
            st_phase = psd_pkg::PH_HDR2;
          end else begin
            st_phase = psd_pkg::PH_PAYLOAD;
            take_byte(d);
            if (!st_to_end) begin
              st_left = st_left - 1'b1;
              if (st_left == 0) st_phase = psd_pkg::PH_SC0;
            end
          end
        end
        psd_pkg::PH_HDR2: begin
          if (st_to_end) begin
            st_held[1] = d;
            st_held_n  = 2'd2;
          end else begin
            st_left = st_left - 1'b1;
          end
          st_phase = psd_pkg::PH_HDR3;
        end
        psd_pkg::PH_HDR3: begin
          st_held_n   = '0;
          st_hdr_left = d;
          if (!st_to_end) begin
            st_left = st_left - 1'b1;
            if ({9'b0, d} > st_left) bad = 1'b1;
            else st_left = st_left - 17'(d);
          end
          if (bad) fail_parse();
          else if (st_hdr_left != 0) st_phase = psd_pkg::PH_HSKIP;
          else if (!st_to_end && st_left == 0) st_phase = psd_pkg::PH_SC0;
          else st_phase = psd_pkg::PH_PAYLOAD;
        end
        psd_pkg::PH_HSKIP: begin
          if (st_hdr_left > 0) st_hdr_left = st_hdr_left - 1'b1;
          if (st_hdr_left == 0) begin
            st_phase = (!st_to_end && st_left == 0) ? psd_pkg::PH_SC0 : psd_pkg::PH_PAYLOAD;
          end
        end
        psd_pkg::PH_PAYLOAD: begin
          take_byte(d);
          if (!st_to_end) begin
            if (st_left > 0) st_left = st_left - 1'b1;
            if (st_left == 0) st_phase = psd_pkg::PH_SC0;
          end
        end
        default: begin
          fail_parse();
        end
      endcase
    end

    // Final byte: flush a cut-short header of a run-to-end packet, then report.
    if (b.end_of_buffer) begin
      ok = 1'b0;
      if (!st_err) begin
        if (st_phase == psd_pkg::PH_SC0) begin
          ok = 1'b1;
        end else if (st_to_end && (st_phase == psd_pkg::PH_HDR1 ||
                                   st_phase == psd_pkg::PH_HDR2 ||
                                   st_phase == psd_pkg::PH_HDR3 ||
                                   st_phase == psd_pkg::PH_PAYLOAD)) begin
          for (int i = 0; i < int'(st_held_n); i++) take_byte(st_held[i]);
          ok = 1'b1;
        end
      end
      if (!ok) begin
        foreach (st_kind[i]) st_kind[i] = '0;
        st_total = '0;
        fin = psd_pkg::STATUS_MALFORMED;
      end else if (st_kind[psd_pkg::KIND_PACK] > 0 && (st_kind[psd_pkg::KIND_VIDEO] > 0 ||
                   st_kind[psd_pkg::KIND_AUDIO] > 0 || st_kind[psd_pkg::KIND_PRIV] > 0)) begin
        fin = psd_pkg::STATUS_ACCEPTED;
      end else begin
        fin = psd_pkg::STATUS_NO_MEDIA;
      end
      emit(1'b0, 8'h00, fin);
      clear_parser();
    end
    if (step_beats.size() > 0) step_beats[step_beats.size() - 1].run_last = 1'b1;
  endtask

  // Mostly short gaps, some medium, a few long; none during quiet stretches.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (quiet) return 0;
    if (r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  // Offer one input beat after a random gap and wait until it is taken.
  task automatic drive_beat(psd_pkg::in_beat_t b, bit typed, psd_pkg::out_beat_t want);
    int            gap;
    typed_expect_t te;
    gap = pick_gap();
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    te.typed = typed;
    te.beat  = want;
    typed_q.insert(typed_q.size(), te);
    in_ch.valid   <= 1'b1;
    in_ch.payload <= b;
    @(posedge clk_i);
    while (!in_ch.ready) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  task automatic lower_valid();
    in_ch.valid <= 1'b0;
    @(negedge clk_i);
  endtask

  task automatic wait_drained();
    while (demux_results_q.size() != 0) @(negedge clk_i);
    repeat (SETTLE) @(negedge clk_i);
  endtask

  function automatic psd_pkg::out_beat_t closing_beat(logic [1:0] status, logic [15:0] packs);
    psd_pkg::out_beat_t r;
    r            = '0;
    r.run_last   = 1'b1;
    r.status     = status;
    r.pack_count = packs;
    return r;
  endfunction

  task automatic add_row(logic [7:0] d, logic eob, bit typed, psd_pkg::out_beat_t want);
    stim_row_t row;
    row.data  = d;
    row.eob   = eob;
    row.typed = typed;
    row.want  = want;
    stim_rows.insert(stim_rows.size(), row);
  endtask

  function automatic logic [7:0] pick_pes_id();
    int r;
    r = $urandom_range(0, 99);
    if (r < 40) return psd_pkg::ID_VIDEO_LO + 8'($urandom_range(0, 15));
    if (r < 65) return psd_pkg::ID_AUDIO_LO + 8'($urandom_range(0, 31));
    if (r < 80) begin
      case ($urandom_range(0, 2))
        0: return psd_pkg::ID_PRIV1;
        1: return psd_pkg::ID_PRIV2;
        default: return psd_pkg::ID_PRIV3;
      endcase
    end
    return psd_pkg::ID_PAD;
  endfunction

  // Append one byte to the buffer under construction.
  task automatic add_byte(logic [7:0] x);
    buf_bytes.insert(buf_bytes.size(), x);
  endtask

  task automatic put_start(logic [7:0] id);
    add_byte(psd_pkg::SC_ZERO);
    add_byte(psd_pkg::SC_ZERO);
    add_byte(psd_pkg::SC_ONE);
    add_byte(id);
  endtask

  // Pack header with random fields and 0..7 stuffing bytes.
  task automatic add_pack();
    int n;
    n = $urandom_range(0, 7);
    put_start(psd_pkg::ID_PACK);
    repeat (9) add_byte(8'($urandom));
    add_byte((8'($urandom) & 8'hF8) | 8'(n));
    repeat (n) add_byte(8'($urandom));
  endtask

  // System header or stream map with a short body.
  task automatic add_table_elem(logic [7:0] id);
    int len;
    len = $urandom_range(0, 8);
    put_start(id);
    add_byte(8'h00);
    add_byte(8'(len));
    repeat (len) add_byte(8'($urandom));
  endtask

  // First payload byte that cannot be taken for an optional header.
  function automatic logic [7:0] plain_byte();
    logic [7:0] x;
    x = 8'($urandom);
    if (x[7:6] == psd_pkg::HDR_MARK) x[6] = 1'b1;
    return x;
  endfunction

  // PES packet, either of known length or running to the end of the buffer.
  task automatic add_pes(logic [7:0] id, bit to_end, int max_pay);
    int h;
    int p;
    int len;
    int k;
    bit with_hdr;
    h        = $urandom_range(0, 4);
    p        = $urandom_range(0, max_pay);
    with_hdr = $urandom_range(0, 1);
    put_start(id);
    if (to_end) begin
      add_byte(8'h00);
      add_byte(8'h00);
      k = $urandom_range(0, 9);
      if (k < 2) begin
        // Header cut short by the end of the buffer.
        add_byte({psd_pkg::HDR_MARK, 6'($urandom)});
        if (k == 1) add_byte(8'($urandom));
      end else if (with_hdr) begin
        add_byte({psd_pkg::HDR_MARK, 6'($urandom)});
        add_byte(8'($urandom));
        add_byte(8'(h));
        repeat (h + p) add_byte(8'($urandom));
      end else if (p > 0) begin
        add_byte(plain_byte());
        repeat (p - 1) add_byte(8'($urandom));
      end
    end else if (with_hdr) begin
      len = 3 + h + p;
      // Now and then the header claims more than the packet holds.
      if (h > 0 && $urandom_range(0, 7) == 0) len = 3 + $urandom_range(0, h - 1);
      add_byte(8'(len >> 8));
      add_byte(8'(len));
      add_byte({psd_pkg::HDR_MARK, 6'($urandom)});
      add_byte(8'($urandom));
      add_byte(8'(h));
      repeat (h + p) add_byte(8'($urandom));
    end else begin
      len = $urandom_range(1, 10);
      add_byte(8'h00);
      add_byte(8'(len));
      // Packets shorter than a header take any first byte as payload.
      add_byte((len < 3) ? 8'($urandom) : plain_byte());
      repeat (len - 1) add_byte(8'($urandom));
    end
  endtask

  // Mostly well-formed buffers; some noise, truncated or corrupted ones.
  task automatic build_buffer();
    int r;
    int n;
    int pick;
    int cut;
    r = $urandom_range(0, 99);
    if (r < 12) begin
      n = $urandom_range(1, 8);
      repeat (n) add_byte(8'($urandom));
    end else begin
      n = $urandom_range(1, 4);
      repeat (n) begin
        pick = $urandom_range(0, 99);
        if (pick < 40) add_pack();
        else if (pick < 55) begin
          add_table_elem($urandom_range(0, 1) ? psd_pkg::ID_SYS : psd_pkg::ID_MAP);
        end
        else add_pes(pick_pes_id(), 1'b0, 8);
      end
      if ($urandom_range(0, 9) < 4) add_pes(pick_pes_id(), 1'b1, 12);
      if (r >= 70 && r < 82 && buf_bytes.size() > 1) begin
        cut = $urandom_range(1, buf_bytes.size() - 1);
        while (buf_bytes.size() > cut) void'(buf_bytes.pop_back());
      end else if (r >= 82 && r < 92) begin
        buf_bytes[$urandom_range(0, buf_bytes.size() - 1)] = 8'($urandom);
      end
    end
  endtask

  // Send the built buffer, marking its last byte.
  task automatic send_buffer();
    psd_pkg::in_beat_t  b;
    psd_pkg::out_beat_t no_beat;
    no_beat = '0;
    foreach (buf_bytes[i]) begin
      b.data_byte     = buf_bytes[i];
      b.end_of_buffer = (i == buf_bytes.size() - 1);
      drive_beat(b, 1'b0, no_beat);
      sent_items++;
    end
    buf_bytes.delete();
  endtask

  task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      $error("%s mismatch: expected %0h, got %0h", name, want, got);
      mismatches++;
    end
  endtask

  // Predict on every accepted input beat and check every accepted output beat.
  always @(posedge clk_i) begin : monitor
    typed_expect_t      te;
    psd_pkg::out_beat_t w;
    psd_pkg::out_beat_t g;
    if (rst_ni && in_ch.valid && in_ch.ready) begin
      te = typed_q.pop_front();
      demux_step(in_ch.payload);
      if (te.typed) demux_results_q.insert(demux_results_q.size(), te.beat);
      else foreach (step_beats[i]) demux_results_q.insert(demux_results_q.size(), step_beats[i]);
    end
    if (rst_ni && out_ch.valid && out_ch.ready) begin
      g = out_ch.payload;
      if (demux_results_q.size() == 0) begin
        $error("result beat arrived with nothing expected");
        mismatches++;
      end else begin
        w = demux_results_q.pop_front();
        check_field("payload_valid", w.payload_valid, g.payload_valid);
        check_field("payload_value", w.payload_value, g.payload_value);
        check_field("run_last", w.run_last, g.run_last);
        check_field("status", w.status, g.status);
        check_field("pack_count", w.pack_count, g.pack_count);
        check_field("system_header_count", w.system_header_count, g.system_header_count);
        check_field("map_count", w.map_count, g.map_count);
        check_field("pes_count", w.pes_count, g.pes_count);
        check_field("video_count", w.video_count, g.video_count);
        check_field("audio_count", w.audio_count, g.audio_count);
        check_field("private_count", w.private_count, g.private_count);
        check_field("payload_total", w.payload_total, g.payload_total);
      end
    end
  end

  // Hard stop on a hang.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  // Output side: random stalls, plus one long hold-off on request.
  initial begin : receiver
    int stall_left;
    int burst_left;
    int hold_left;
    out_ch.ready = 1'b0;
    stall_left   = 0;
    burst_left   = 0;
    hold_left    = 0;
    forever begin
      @(negedge clk_i);
      if (hold_req) begin
        hold_req  = 1'b0;
        hold_left = LONG_HOLD;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ch.ready <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= 1'b1;
        if (burst_left > 0) begin
          burst_left--;
        end else begin
          stall_left = pick_gap();
          burst_left = $urandom_range(0, 12);
        end
      end
    end
  end

  // Main sequence: reset, directed table, then random buffers.
  initial begin : stimulus
    int                 buf_no;
    psd_pkg::in_beat_t  b;
    psd_pkg::out_beat_t no_beat;
    in_ch.valid   = 1'b0;
    in_ch.payload = '0;
    rst_ni        = 1'b0;
    no_beat       = '0;
    clear_parser();

    // Lone bytes right after reset: the first ends the buffer inside a start code, the second breaks it.
    add_row(psd_pkg::SC_ZERO, 1'b1, 1'b1, closing_beat(psd_pkg::STATUS_MALFORMED, 16'd0));
    add_row(8'hFF, 1'b1, 1'b1, closing_beat(psd_pkg::STATUS_MALFORMED, 16'd0));
    // A bare pack header with all-ones and all-zero fields and no stuffing.
    add_row(psd_pkg::SC_ZERO, 1'b0, 1'b0, no_beat);
    add_row(psd_pkg::SC_ZERO, 1'b0, 1'b0, no_beat);
    add_row(psd_pkg::SC_ONE, 1'b0, 1'b0, no_beat);
    add_row(psd_pkg::ID_PACK, 1'b0, 1'b0, no_beat);
    for (int i = 0; i < 9; i++) add_row((i % 2 == 0) ? 8'hFF : 8'h00, 1'b0, 1'b0, no_beat);
    add_row(8'hF8, 1'b1, 1'b1, closing_beat(psd_pkg::STATUS_NO_MEDIA, 16'd1));
    // Run-to-end video packet whose header is cut short after two bytes.
    add_row(psd_pkg::SC_ZERO, 1'b0, 1'b0, no_beat);
    add_row(psd_pkg::SC_ZERO, 1'b0, 1'b0, no_beat);
    add_row(psd_pkg::SC_ONE, 1'b0, 1'b0, no_beat);
    add_row(psd_pkg::ID_VIDEO_HI, 1'b0, 1'b0, no_beat);
    add_row(8'h00, 1'b0, 1'b0, no_beat);
    add_row(8'h00, 1'b0, 1'b0, no_beat);
    add_row({psd_pkg::HDR_MARK, 6'h00}, 1'b0, 1'b0, no_beat);
    add_row(8'hFF, 1'b1, 1'b0, no_beat);

    repeat (11) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    foreach (stim_rows[i]) begin
      b.data_byte     = stim_rows[i].data;
      b.end_of_buffer = stim_rows[i].eob;
      drive_beat(b, stim_rows[i].typed, stim_rows[i].want);
    end
    lower_valid();
    wait_drained();

    buf_no = 0;
    while (sent_items < ITEM_GOAL) begin
      quiet = (buf_no % 6 == 5);
      if (buf_no == 2) begin
        // Long output hold-off while a video-heavy buffer keeps coming.
        hold_req = 1'b1;
        add_pack();
        add_pes(psd_pkg::ID_VIDEO_LO, 1'b0, 24);
        add_pes(psd_pkg::ID_VIDEO_HI, 1'b1, 24);
      end else begin
        build_buffer();
      end
      send_buffer();
      if (buf_no == 5) begin
        lower_valid();
        wait_drained();
      end
      buf_no++;
    end
    lower_valid();
    wait_drained();

    if (mismatches == 0 && demux_results_q.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
